// ===== rtl/esc_pkg.sv =====
// ---------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation block.
// ---------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID      = 3'd4;

    // pipeline geometry
    localparam int unsigned FRONT_STAGES = 11;
    localparam int unsigned BACK_STAGES  = 6;
    localparam int unsigned DIV_W        = 64;
    localparam int unsigned DIV_STEPS    = 2;
    localparam int unsigned DIV_STAGES   = DIV_W / DIV_STEPS;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_humid;
        logic [7:0]  status_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic [16:0]        humidity;
        logic               busy_res;
        logic               press_invalid;
    } t_out_word;

    typedef struct packed {
        logic [47:0] temp_coeffs;
        logic [47:0] press_coeffs_low;
        logic [47:0] press_coeffs_mid;
        logic [47:0] press_coeffs_high;
        logic [63:0] humid_coeffs;
    } t_coef;

    // results that ride alongside the divider
    typedef struct packed {
        logic [31:0] temperature;
        logic [16:0] humidity;
        logic        busy;
        logic        inval;
        logic        qneg;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        t_side            side;
    } t_div_word;

    typedef struct packed {
        logic [DIV_W-1:0] quo;
        t_side            side;
    } t_quo_word;

endpackage

`default_nettype wire

// ===== rtl/env_sensor_compensation.sv =====
// ---------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of temperature, pressure and humidity sample sets.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  in       | i_in_valid / o_in_stall   | i_in_data  (t_in_word)
//  out      | o_out_valid / i_out_stall | o_out_data (t_out_word)
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One word per cycle while the output is not stalled; 11 front stages, 32 divider
//  stages of two quotient bits each, 6 back stages with the output register.
//  The 64-bit pressure divider sets the depth.
//  Reset clears the valid bits and the coefficient registers.
//  A stall on a valid output word freezes every stage and stalls the input.
// ---------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation
    import esc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    t_coef     r_coef;
    logic      en;
    logic      front_valid, div_valid;
    t_div_word front_word;
    t_quo_word div_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEMP:       r_coef.temp_coeffs       <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_coef.press_coeffs_low  <= i_cfg_data[47:0];
                CFG_PRESS_MID:  r_coef.press_coeffs_mid  <= i_cfg_data[47:0];
                CFG_PRESS_HIGH: r_coef.press_coeffs_high <= i_cfg_data[47:0];
                CFG_HUMID:      r_coef.humid_coeffs      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless the output word is held
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_coef  (r_coef),
        .i_valid (i_in_valid),
        .i_word  (i_in_data),
        .o_valid (front_valid),
        .o_word  (front_word)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_word  (front_word),
        .o_valid (div_valid),
        .o_word  (div_word)
    );

    esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_coef  (r_coef),
        .i_valid (div_valid),
        .i_word  (div_word),
        .o_valid (o_out_valid),
        .o_word  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/esc_front.sv =====
// ---------------------------------------------------------------------------
// esc_front
// Temperature and humidity compensation, pressure numerator and divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_front
    import esc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_coef     i_coef,
    input  wire logic      i_valid,
    input  wire t_in_word  i_word,
    output logic           o_valid,
    output t_div_word      o_word
);

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2;
    logic [7:0]         h1, h3;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1 = i_coef.temp_coeffs[15:0];
    assign t2 = i_coef.temp_coeffs[31:16];
    assign t3 = i_coef.temp_coeffs[47:32];
    assign p1 = i_coef.press_coeffs_low[15:0];
    assign p2 = i_coef.press_coeffs_low[31:16];
    assign p3 = i_coef.press_coeffs_low[47:32];
    assign p4 = i_coef.press_coeffs_mid[15:0];
    assign p5 = i_coef.press_coeffs_mid[31:16];
    assign p6 = i_coef.press_coeffs_mid[47:32];
    assign h1 = i_coef.humid_coeffs[7:0];
    assign h2 = i_coef.humid_coeffs[23:8];
    assign h3 = i_coef.humid_coeffs[31:24];
    assign h4 = i_coef.humid_coeffs[43:32];
    assign h5 = i_coef.humid_coeffs[55:44];
    assign h6 = i_coef.humid_coeffs[63:56];

    logic [FRONT_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end
    end

    // stage 1
    logic [31:0] s1_v1a, s1_d;
    logic [31:0] r_v1p, r_dd;
    logic [19:0] r_ap1;
    logic [15:0] r_ah1;
    logic        r_busy1;

    assign s1_v1a = {15'd0, i_word.raw_temp[19:3]} - {15'd0, t1, 1'b0};
    assign s1_d   = {16'd0, i_word.raw_temp[19:4]} - {16'd0, t1};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1p   <= s1_v1a * {{16{t2[15]}}, t2};
            r_dd    <= s1_d * s1_d;
            r_ap1   <= i_word.raw_press;
            r_ah1   <= i_word.raw_humid;
            r_busy1 <= (i_word.status_byte[3] | i_word.status_byte[0]);
        end
    end

    // stage 2
    logic [31:0] s2_v1, s2_dds;
    logic [31:0] r_v1, r_m;
    logic [19:0] r_ap2;
    logic [15:0] r_ah2;
    logic        r_busy2;

    assign s2_v1  = $signed(r_v1p) >>> 11;
    assign s2_dds = $signed(r_dd) >>> 12;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1    <= s2_v1;
            r_m     <= s2_dds * {{16{t3[15]}}, t3};
            r_ap2   <= r_ap1;
            r_ah2   <= r_ah1;
            r_busy2 <= r_busy1;
        end
    end

    // stage 3: fine temperature
    logic [31:0] s3_v2;
    logic [31:0] r_tf;
    logic [19:0] r_ap3;
    logic [15:0] r_ah3;
    logic        r_busy3;

    assign s3_v2 = $signed(r_m) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tf    <= r_v1 + s3_v2;
            r_ap3   <= r_ap2;
            r_ah3   <= r_ah2;
            r_busy3 <= r_busy2;
        end
    end

    // stage 4
    logic [31:0]        s4_t5, s4_temp, s4_x;
    logic signed [33:0] s4_a;
    logic [63:0]        r_aa, r_ap5, r_ap2c;
    logic [31:0]        r_h5x, r_xh6, r_xh3, r_temp4;
    logic [19:0]        r_ap4;
    logic [15:0]        r_ah4;
    logic               r_busy4;

    assign s4_t5   = r_tf * 32'd5 + 32'd128;
    assign s4_temp = $signed(s4_t5) >>> 8;
    assign s4_a    = {{2{r_tf[31]}}, r_tf} - 34'd128000;
    assign s4_x    = r_tf - 32'd76800;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa    <= 64'(s4_a * s4_a);
            r_ap5   <= 64'(s4_a * p5);
            r_ap2c  <= 64'(s4_a * p2);
            r_h5x   <= s4_x * {{20{h5[11]}}, h5};
            r_xh6   <= s4_x * {{24{h6[7]}}, h6};
            r_xh3   <= s4_x * {24'd0, h3};
            r_temp4 <= s4_temp;
            r_ap4   <= r_ap3;
            r_ah4   <= r_ah3;
            r_busy4 <= r_busy3;
        end
    end

    // stage 5
    logic [31:0] s5_hsum, s5_ha, s5_hb, s5_hcs, s5_hc;
    logic [63:0] r_b1, r_a3, r_ap5d, r_ap2d;
    logic [31:0] r_ha5, r_hbc, r_temp5;
    logic [19:0] r_ap5r;
    logic        r_busy5;

    assign s5_hsum = {2'd0, r_ah4, 14'd0} - {h4, 20'd0} - r_h5x + 32'd16384;
    assign s5_ha   = $signed(s5_hsum) >>> 15;
    assign s5_hb   = $signed(r_xh6) >>> 10;
    assign s5_hcs  = $signed(r_xh3) >>> 11;
    assign s5_hc   = s5_hcs + 32'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1    <= 64'($signed(r_aa) * p6);
            r_a3    <= 64'($signed(r_aa) * p3);
            r_ap5d  <= r_ap5;
            r_ap2d  <= r_ap2c;
            r_ha5   <= s5_ha;
            r_hbc   <= s5_hb * s5_hc;
            r_temp5 <= r_temp4;
            r_ap5r  <= r_ap4;
            r_busy5 <= r_busy4;
        end
    end

    // stage 6
    logic [63:0] s6_a3s;
    logic [31:0] s6_hbcs, s6_he;
    logic [63:0] r_b, r_a6;
    logic [31:0] r_hep, r_ha6, r_temp6;
    logic [19:0] r_ap6;
    logic        r_busy6;

    assign s6_a3s  = $signed(r_a3) >>> 8;
    assign s6_hbcs = $signed(r_hbc) >>> 10;
    assign s6_he   = s6_hbcs + 32'd2097152;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b     <= r_b1 + {r_ap5d[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
            r_a6    <= s6_a3s + {r_ap2d[51:0], 12'd0};
            r_hep   <= s6_he * {{16{h2[15]}}, h2};
            r_ha6   <= r_ha5;
            r_temp6 <= r_temp5;
            r_ap6   <= r_ap5r;
            r_busy6 <= r_busy5;
        end
    end

    // stage 7
    logic [63:0] s7_dsum, s7_pn;
    logic [20:0] s7_p;
    logic [31:0] s7_hep, s7_hf;
    logic [63:0] r_dp, r_pn;
    logic [31:0] r_hf, r_ha7, r_temp7;
    logic        r_busy7;

    assign s7_dsum = 64'h0000_8000_0000_0000 + r_a6;
    assign s7_p    = 21'd1048576 - {1'b0, r_ap6};
    assign s7_pn   = {12'd0, s7_p, 31'd0} - r_b;
    assign s7_hep  = r_hep + 32'd8192;
    assign s7_hf   = $signed(s7_hep) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp    <= s7_dsum * {48'd0, p1};
            r_pn    <= s7_pn;
            r_hf    <= s7_hf;
            r_ha7   <= r_ha6;
            r_temp7 <= r_temp6;
            r_busy7 <= r_busy6;
        end
    end

    // stage 8: divisor and numerator
    logic [63:0] s8_den;
    logic [63:0] r_den, r_num;
    logic [31:0] r_hx8, r_temp8;
    logic        r_busy8;

    assign s8_den = $signed(r_dp) >>> 33;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= s8_den;
            r_num   <= r_pn * 64'd3125;
            r_hx8   <= r_ha7 * r_hf;
            r_temp8 <= r_temp7;
            r_busy8 <= r_busy7;
        end
    end

    // stage 9: take magnitudes for the unsigned divider
    logic [31:0] s9_g;
    logic [63:0] r_mn, r_md;
    logic [31:0] r_gg, r_hx9, r_temp9;
    logic        r_busy9, r_inval9, r_qneg9;

    assign s9_g = $signed(r_hx8) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mn     <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_md     <= r_den[63] ? (64'd0 - r_den) : r_den;
            r_qneg9  <= r_num[63] ^ r_den[63];
            r_inval9 <= (r_den == 64'd0);
            r_gg     <= s9_g * s9_g;
            r_hx9    <= r_hx8;
            r_temp9  <= r_temp8;
            r_busy9  <= r_busy8;
        end
    end

    // stage 10
    logic [31:0] s10_ggs;
    logic [63:0] r_mn10, r_md10;
    logic [31:0] r_ggh, r_hx10, r_temp10;
    logic        r_busy10, r_inval10, r_qneg10;

    assign s10_ggs = $signed(r_gg) >>> 7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ggh     <= s10_ggs * {24'd0, h1};
            r_mn10    <= r_mn;
            r_md10    <= r_md;
            r_qneg10  <= r_qneg9;
            r_inval10 <= r_inval9;
            r_hx10    <= r_hx9;
            r_temp10  <= r_temp9;
            r_busy10  <= r_busy9;
        end
    end

    // stage 11: humidity clamp
    logic [31:0] s11_ghs, s11_x, s11_xc;
    t_div_word   r_word;

    assign s11_ghs = $signed(r_ggh) >>> 4;
    assign s11_x   = r_hx10 - s11_ghs;

    always_comb begin
        if (s11_x[31]) begin
            s11_xc = 32'd0;
        end else if (s11_x > 32'd419430400) begin
            s11_xc = 32'd419430400;
        end else begin
            s11_xc = s11_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word.num              <= r_mn10;
            r_word.den              <= r_md10;
            r_word.side.temperature <= r_temp10;
            r_word.side.humidity    <= s11_xc[28:12];
            r_word.side.busy        <= r_busy10;
            r_word.side.inval       <= r_inval10;
            r_word.side.qneg        <= r_qneg10;
        end
    end

    assign o_valid = r_vld[FRONT_STAGES-1];
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== rtl/esc_div.sv =====
// ---------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_div
    import esc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire logic      i_valid,
    input  wire t_div_word i_word,
    output logic           o_valid,
    output t_quo_word      o_word
);

    logic             r_v    [DIV_STAGES];
    logic [DIV_W:0]   r_rem  [DIV_STAGES];
    logic [DIV_W-1:0] r_dq   [DIV_STAGES];
    logic [DIV_W-1:0] r_den  [DIV_STAGES];
    t_side            r_side [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic             c_v;
        logic [DIV_W:0]   c_rem;
        logic [DIV_W-1:0] c_dq;
        logic [DIV_W-1:0] c_den;
        t_side            c_side;
        logic [DIV_W:0]   n_rem;
        logic [DIV_W-1:0] n_dq;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_dq   = i_word.num;
            assign c_den  = i_word.den;
            assign c_side = i_word.side;
        end else begin : g_next
            assign c_v    = r_v[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_dq   = r_dq[k-1];
            assign c_den  = r_den[k-1];
            assign c_side = r_side[k-1];
        end

        // shift in the next dividend bit, subtract where it fits
        always_comb begin
            n_rem = c_rem;
            n_dq  = c_dq;
            for (int j = 0; j < DIV_STEPS; j++) begin
                n_rem = {n_rem[DIV_W-1:0], n_dq[DIV_W-1]};
                n_dq  = {n_dq[DIV_W-2:0], 1'b0};
                if (n_rem >= {1'b0, c_den}) begin
                    n_rem   = n_rem - {1'b0, c_den};
                    n_dq[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_dq[k]   <= n_dq;
                r_den[k]  <= c_den;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_valid     = r_v[DIV_STAGES-1];
    assign o_word.quo  = r_dq[DIV_STAGES-1];
    assign o_word.side = r_side[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/esc_back.sv =====
// ---------------------------------------------------------------------------
// esc_back
// Pressure correction after the division and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_back
    import esc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_coef     i_coef,
    input  wire logic      i_valid,
    input  wire t_quo_word i_word,
    output logic           o_valid,
    output t_out_word      o_word
);

    logic signed [15:0] p7, p8, p9;

    assign p7 = i_coef.press_coeffs_high[15:0];
    assign p8 = i_coef.press_coeffs_high[31:16];
    assign p9 = i_coef.press_coeffs_high[47:32];

    logic [BACK_STAGES-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[BACK_STAGES-2:0], i_valid};
        end
    end

    // stage 1: restore quotient sign
    logic [63:0] r_q1;
    t_side       r_side1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1    <= i_word.side.qneg ? (64'd0 - i_word.quo) : i_word.quo;
            r_side1 <= i_word.side;
        end
    end

    // stage 2: partial products of the square
    logic [63:0] s2_qs;
    logic [63:0] r_qll, r_q2, r_p8p2;
    logic [30:0] r_qhl;
    t_side       r_side2;

    assign s2_qs = $signed(r_q1) >>> 13;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qll   <= {32'd0, s2_qs[31:0]} * {32'd0, s2_qs[31:0]};
            r_qhl   <= 31'(s2_qs[62:32] * s2_qs[31:0]);
            r_p8p2  <= 64'($signed(r_q1) * p8);
            r_q2    <= r_q1;
            r_side2 <= r_side1;
        end
    end

    // stage 3
    logic [63:0] r_qq, r_q3, r_p8p3;
    t_side       r_side3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qq    <= r_qll + {r_qhl, 33'd0};
            r_q3    <= r_q2;
            r_p8p3  <= r_p8p2;
            r_side3 <= r_side2;
        end
    end

    // stage 4
    logic [63:0] r_p9q, r_q4, r_p8p4;
    t_side       r_side4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p9q   <= 64'($signed(r_qq) * p9);
            r_q4    <= r_q3;
            r_p8p4  <= r_p8p3;
            r_side4 <= r_side3;
        end
    end

    // stage 5
    logic [63:0] s5_a, s5_b;
    logic [63:0] r_sum;
    t_side       r_side5;

    assign s5_a = $signed(r_p9q) >>> 25;
    assign s5_b = $signed(r_p8p4) >>> 19;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= r_q4 + s5_a + s5_b;
            r_side5 <= r_side4;
        end
    end

    // stage 6: output word
    logic [63:0] s6_sh;
    logic [31:0] s6_pres;
    t_out_word   r_out;

    assign s6_sh   = $signed(r_sum) >>> 8;
    assign s6_pres = s6_sh[31:0] + {{12{p7[15]}}, p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.temperature   <= r_side5.temperature;
            r_out.pressure      <= r_side5.inval ? 32'd0 : s6_pres;
            r_out.humidity      <= r_side5.humidity;
            r_out.busy_res      <= r_side5.busy;
            r_out.press_invalid <= r_side5.inval;
        end
    end

    assign o_valid = r_vld[BACK_STAGES-1];
    assign o_word  = r_out;

endmodule

`default_nettype wire

// ===== rtl/esc_checker.sv =====
// ---------------------------------------------------------------------------
// esc_checker
// Port-level checks of the compensation block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module esc_checker
    import esc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_out_word            o_out_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.humidity <= 17'd102400)
                         && (!o_out_data.press_invalid || o_out_data.pressure == 32'd0)))
        else $error("humidity out of range or invalid pressure not zero");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);

`default_nettype wire
